/* rtl/wss_pkg.sv */
// ============================================================================
// wss_pkg
// Shared types, constants and register indexes for the wildcard signature
// scanner.
// ============================================================================
package wss_pkg;

    // Signature geometry
    localparam int SIG_LEN_DEF = 14;
    localparam int SIG_LEN_MAX = 14;
    localparam int PAT_W       = 8 * SIG_LEN_MAX;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_LOW_W  = 64;
    localparam int PAT_HIGH_W = 48;
    localparam int OFFSET_W   = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WILD_MASK    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STORE_OFFSET = 4'd3;

    localparam logic [OFFSET_W-1:0] STORE_OFFSET_RST = 4'd8;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Result codes
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_UNIQUE = 2'd1,
        ST_MULTI  = 2'd2
    } t_scan_status;

    // One scanned byte
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [31:0] byte_address;
        logic        section_start;
        logic        scan_end;
    } t_in_item;

    // One scan result
    typedef struct packed {
        logic [1:0]  scan_status;
        logic [31:0] hit_address;
    } t_out_item;

    // Classified byte handed from front to back
    typedef struct packed {
        logic        hit;
        logic [31:0] start;
        logic        last;
    } t_hit_entry;

endpackage

/* rtl/wss_front.sv */
// ============================================================================
// wss_front
// Takes in scanned bytes, shifts them through the signature window and
// classifies each byte as a hit or a miss against the masked signature.
// ============================================================================
module wss_front import wss_pkg::*; #(
    parameter int SIG_LEN = SIG_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_in_item               i_item,
    input  logic [PAT_W-1:0]       i_pattern,
    input  logic [SIG_LEN_MAX-1:0] i_wild_mask,
    output logic                   o_push,
    output t_hit_entry             o_entry,
    input  logic                   i_full
);

    localparam int FILL_W = $clog2(SIG_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SIG_LEN);
    localparam logic [31:0] START_BACK = 32'(SIG_LEN - 1);

    logic [SIG_LEN-1:0][7:0] r_window;
    logic [SIG_LEN-1:0][7:0] n_window;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic [FILL_W-1:0]       base_fill;
    logic                    accept;
    logic                    match;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Shift the new byte in and compare the window against the signature
    always_comb begin
        for (int i = 0; i < SIG_LEN - 1; i++) begin
            n_window[i] = r_window[i + 1];
        end
        n_window[SIG_LEN-1] = i_item.byte_value;

        base_fill = i_item.section_start ? '0 : r_fill;
        n_fill    = (base_fill == FILL_FULL) ? base_fill : base_fill + 1'b1;

        match = 1'b1;
        for (int i = 0; i < SIG_LEN; i++) begin
            if (!i_wild_mask[i] && (n_window[i] != i_pattern[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // Hand the classified byte to the queue
    always_comb begin
        o_push        = accept;
        o_entry.hit   = (n_fill == FILL_FULL) && match;
        o_entry.start = i_item.byte_address - START_BACK;
        o_entry.last  = i_item.scan_end;
    end

    // Window contents only count below the fill level, so they need no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

    // Track the fill level; restart it at a section start, drop it at the end of a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= i_item.scan_end ? '0 : n_fill;
        end
    end

endmodule

/* rtl/wss_queue.sv */
// ============================================================================
// wss_queue
// Short first-in first-out queue of classified bytes between front and back.
// ============================================================================
module wss_queue import wss_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_hit_entry i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_empty,
    output t_hit_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_hit_entry       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/wss_back.sv */
// ============================================================================
// wss_back
// Counts hits per scan, keeps the first hit address and emits the scan result
// through an output register on the last byte.
// ============================================================================
module wss_back import wss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_hit_entry          i_entry,
    output logic                o_pop,
    input  logic [OFFSET_W-1:0] i_store_offset,
    output logic                o_valid,
    input  logic                i_ready,
    output t_out_item           o_item
);

    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic [31:0] r_first;
    logic [31:0] n_first;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;
    logic        out_free;
    logic        emit;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = !i_empty && (!i_entry.last || out_free);
    assign emit     = o_pop && i_entry.last;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out_item;

    // Update the saturating hit count and the first hit, build the result
    always_comb begin
        n_count = r_count;
        n_first = r_first;
        if (i_entry.hit) begin
            if (r_count == 2'd0) begin
                n_first = i_entry.start;
            end
            if (r_count != 2'd2) begin
                n_count = r_count + 1'b1;
            end
        end

        n_out_item = '0;
        case (n_count)
            2'd0: begin
                n_out_item.scan_status = ST_NONE;
            end
            2'd1: begin
                n_out_item.scan_status = ST_UNIQUE;
                n_out_item.hit_address = n_first + 32'(i_store_offset);
            end
            default: begin
                n_out_item.scan_status = ST_MULTI;
            end
        endcase
    end

    // Hold scan progress; clear it when the result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
        end else if (o_pop) begin
            r_count <= emit ? '0 : n_count;
            r_first <= emit ? '0 : n_first;
        end
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

/* rtl/wildcard_signature_scanner_top.sv */
// ============================================================================
// wildcard_signature_scanner_top
// Scans a byte stream for a masked signature and reports none, one or many.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one byte with
//   its address and the section start and scan end flags per transfer.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one result
//   per scan, after the byte flagged as scan end.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while no scan is in flight.
// Throughput: one byte per cycle while the queue has room. The front compares
//   the whole window in the cycle a byte arrives and pushes into a four-entry
//   queue; the back drains one entry per cycle unless a scan end entry waits
//   for a free output register. The scan end entry leaves the queue after
//   any entries ahead of it, and the result is then registered for output.
// Stall: when the receiver holds i_out_ready low, the result waits in the
//   output register; bytes keep flowing until the queue fills behind the next
//   scan end, then o_in_ready drops.
// Reset: synchronous, active low; clears scan progress and the queue, sets
//   all patterns and masks to zero and the store offset to eight.
// ============================================================================
module wildcard_signature_scanner_top import wss_pkg::*; #(
    parameter int SIG_LEN     = SIG_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PAT_LOW_W-1:0]   r_pattern_low;
    logic [PAT_HIGH_W-1:0]  r_pattern_high;
    logic [SIG_LEN_MAX-1:0] r_wild_mask;
    logic [OFFSET_W-1:0]    r_store_offset;
    logic [PAT_W-1:0]       pattern;

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    t_hit_entry push_entry;
    t_hit_entry pop_entry;

    assign o_cfg_ready = 1'b1;
    assign pattern     = {r_pattern_high, r_pattern_low};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_wild_mask    <= '0;
            r_store_offset <= STORE_OFFSET_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pattern_low  <= i_cfg_data[PAT_LOW_W-1:0];
                CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_data[PAT_HIGH_W-1:0];
                CFG_WILD_MASK:    r_wild_mask    <= i_cfg_data[SIG_LEN_MAX-1:0];
                CFG_STORE_OFFSET: r_store_offset <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wss_front #(
        .SIG_LEN (SIG_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .i_pattern   (pattern),
        .i_wild_mask (r_wild_mask),
        .o_push      (push),
        .o_entry     (push_entry),
        .i_full      (q_full)
    );

    wss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (pop_entry)
    );

    wss_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_entry        (pop_entry),
        .o_pop          (pop),
        .i_store_offset (r_store_offset),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_item         (o_out_item)
    );

endmodule

/* rtl/wss_checker.sv */
// ============================================================================
// wss_checker
// Port-level checks on the wildcard signature scanner, bound to the top.
// ============================================================================
module wss_checker import wss_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in_item              i_in_item,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_item,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    logic [3:0] r_pending;
    logic       end_xfer;
    logic       out_xfer;

    assign end_xfer = i_in_valid && o_in_ready && i_in_item.scan_end;
    assign out_xfer = o_out_valid && i_out_ready;

    // Count scans whose result has not yet transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (end_xfer && !out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_xfer && !end_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Only a unique match carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.scan_status != ST_UNIQUE)
            |-> (o_out_item.hit_address == 32'd0))
        else $error("address on a non-unique result");

    // No result without a finished scan behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 4'd0))
        else $error("result without scan end");

    // Output is idle in the first cycle out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind wildcard_signature_scanner_top wss_checker u_wss_checker (.*);
